[hdl/dvru_pkg.sv]
// ----------------------------------------------------------------------------
// dvru_pkg
// shared types and codes of the distance vector route update engine
// ----------------------------------------------------------------------------
package dvru_pkg;

   localparam int IFACE_SLOTS = 4;

   localparam logic [1:0] KIND_ADVERT  = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_INSTALL = 2'd2;

   localparam logic [2:0] ACT_APPENDED  = 3'd0;
   localparam logic [2:0] ACT_REPLACED  = 3'd1;
   localparam logic [2:0] ACT_KEPT      = 3'd2;
   localparam logic [2:0] ACT_REFUSED   = 3'd3;
   localparam logic [2:0] ACT_FULL      = 3'd4;
   localparam logic [2:0] ACT_READ      = 3'd5;
   localparam logic [2:0] ACT_BADIDX    = 3'd6;
   localparam logic [2:0] ACT_INSTALLED = 3'd7;

   localparam logic [2:0] REG_IFACE_0     = 3'd0;
   localparam logic [2:0] REG_IFACE_1     = 3'd1;
   localparam logic [2:0] REG_IFACE_2     = 3'd2;
   localparam logic [2:0] REG_IFACE_3     = 3'd3;
   localparam logic [2:0] REG_IFACE_COUNT = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [31:0] dest;
      logic [7:0]  cost;
      logic [31:0] next_hop;
      logic [31:0] iface;
   } entry_type;

   typedef struct packed {
      logic                  shift;
      entry_type             tail;
   } chain_ctl_type;

   typedef struct packed {
      logic [IFACE_SLOTS-1:0][31:0] addr;
      logic [2:0]                   count;
   } own_cfg_type;

endpackage

[hdl/dvru_cell.sv]
// ----------------------------------------------------------------------------
// dvru_cell
// one table slot of the rotating route chain
// ----------------------------------------------------------------------------
module dvru_cell (
   input  logic                clock,
   input  logic                shift,
   input  dvru_pkg::entry_type from_next,
   output dvru_pkg::entry_type entry
);

   dvru_pkg::entry_type entry_ff;
   dvru_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (shift) begin
         entry_in = from_next;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[hdl/dvru_ctrl.sv]
// ----------------------------------------------------------------------------
// dvru_ctrl
// sequencer at the head of the chain: compares, rewrites and reports
// ----------------------------------------------------------------------------
module dvru_ctrl #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dvru_pkg::own_cfg_type   own_cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_kind,
   input  logic [31:0]             req_dest_addr,
   input  logic [7:0]              req_route_cost,
   input  logic [31:0]             req_route_next_hop,
   input  logic [31:0]             req_sender_addr,
   input  logic [31:0]             req_arrival_iface,
   input  logic                    req_first_in_message,
   input  logic [5:0]              req_read_index,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_action,
   output logic [5:0]              rsp_entry_index,
   output logic [31:0]             rsp_entry_dest,
   output logic [7:0]              rsp_entry_cost,
   output logic [31:0]             rsp_entry_next_hop,
   output logic [31:0]             rsp_entry_iface,
   output logic [6:0]              rsp_entry_count,
   input  dvru_pkg::entry_type     head,
   output dvru_pkg::chain_ctl_type chain_ctl
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = CW + 7;

   dvru_pkg::state_type state_ff, state_in;

   logic [IW-1:0]       k_ff, k_in;
   logic [CW-1:0]       valid_ff, valid_in;
   logic [CW-1:0]       limit_ff, limit_in;
   logic [CW-1:0]       lim_ff, lim_in;
   logic [1:0]          kind_ff, kind_in;
   logic [31:0]         dest_ff, dest_in;
   logic [7:0]          cost_ff, cost_in;
   logic [31:0]         hop_ff, hop_in;
   logic [31:0]         iface_ff, iface_in;
   logic [5:0]          ridx_ff, ridx_in;
   logic                own_ff, own_in;
   logic                found_ff, found_in;
   logic                decided_ff, decided_in;
   logic                grow_ff, grow_in;
   logic [2:0]          act_ff, act_in;
   logic [5:0]          idx_ff, idx_in;
   dvru_pkg::entry_type res_ff, res_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_act_ff, rsp_act_in;
   logic [5:0]          rsp_idx_ff, rsp_idx_in;
   dvru_pkg::entry_type rsp_entry_ff, rsp_entry_in;
   logic [6:0]          rsp_count_ff, rsp_count_in;

   logic                accept;
   logic                shift;
   logic                load;
   logic                last_step;
   logic [2:0]          own_count;
   logic                own_hit;
   logic [7:0]          newc;
   logic [CW-1:0]       limit_new;
   logic [XW-1:0]       k_x;
   logic [XW-1:0]       valid_x;
   logic [XW-1:0]       lim_x;
   logic [XW-1:0]       ridx_x;
   logic [XW-1:0]       count_x;
   logic [CW-1:0]       count_next;
   logic                match;
   dvru_pkg::entry_type fresh;
   dvru_pkg::entry_type tail;

   assign k_x       = XW'(k_ff);
   assign valid_x   = XW'(valid_ff);
   assign lim_x     = XW'(lim_ff);
   assign ridx_x    = XW'(ridx_ff);
   assign last_step = (k_ff == IW'(TABLE_DEPTH - 1));
   assign fresh     = '{dest: dest_ff, cost: cost_ff, next_hop: hop_ff, iface: iface_ff};
   assign count_next = valid_ff + CW'(grow_ff);
   assign count_x    = XW'(count_next);

   // own interface check on the advertised next hop
   always_comb begin
      own_count = own_cfg.count;
      if (own_cfg.count > 3'(dvru_pkg::IFACE_SLOTS)) begin
         own_count = 3'(dvru_pkg::IFACE_SLOTS);
      end
      own_hit = 1'b0;
      for (int i = 0; i < dvru_pkg::IFACE_SLOTS; i++) begin
         if ((3'(i) < own_count) && (own_cfg.addr[i] == req_route_next_hop)) begin
            own_hit = 1'b1;
         end
      end
   end

   assign newc = (req_route_cost == 8'hFF) ? 8'hFF : req_route_cost + 8'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dvru_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dvru_pkg::ST_SCAN;
            end
         end
         dvru_pkg::ST_SCAN: begin
            if (last_step) begin
               state_in = dvru_pkg::ST_FINISH;
            end
         end
         dvru_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = dvru_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dvru_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      shift     = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         dvru_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         dvru_pkg::ST_SCAN: begin
            shift = 1'b1;
         end
         dvru_pkg::ST_FINISH: begin
            load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   // item datapath
   always_comb begin
      k_in       = k_ff;
      valid_in   = valid_ff;
      limit_in   = limit_ff;
      lim_in     = lim_ff;
      kind_in    = kind_ff;
      dest_in    = dest_ff;
      cost_in    = cost_ff;
      hop_in     = hop_ff;
      iface_in   = iface_ff;
      ridx_in    = ridx_ff;
      own_in     = own_ff;
      found_in   = found_ff;
      decided_in = decided_ff;
      grow_in    = grow_ff;
      act_in     = act_ff;
      idx_in     = idx_ff;
      res_in     = res_ff;
      limit_new  = limit_ff;
      tail       = head;
      match      = 1'b0;

      if (accept) begin
         if ((req_kind == dvru_pkg::KIND_ADVERT) && req_first_in_message) begin
            limit_new = valid_ff;
         end
         limit_in   = limit_new;
         lim_in     = (limit_new < valid_ff) ? limit_new : valid_ff;
         k_in       = '0;
         kind_in    = req_kind;
         dest_in    = req_dest_addr;
         iface_in   = req_arrival_iface;
         ridx_in    = req_read_index;
         own_in     = own_hit;
         found_in   = 1'b0;
         decided_in = 1'b0;
         grow_in    = 1'b0;
         res_in     = '0;
         idx_in     = '0;
         act_in     = dvru_pkg::ACT_FULL;
         cost_in    = req_route_cost;
         hop_in     = req_route_next_hop;
         case (req_kind)
            dvru_pkg::KIND_ADVERT: begin
               cost_in = newc;
               hop_in  = req_sender_addr;
            end
            dvru_pkg::KIND_INSTALL: begin
               act_in = dvru_pkg::ACT_FULL;
            end
            default: begin
               act_in = dvru_pkg::ACT_BADIDX;
               idx_in = req_read_index;
            end
         endcase
      end

      if (shift) begin
         k_in = k_ff + IW'(1);
         case (kind_ff)
            dvru_pkg::KIND_ADVERT: begin
               match = (k_x < lim_x) && (head.dest == dest_ff) && !decided_ff;
               if (match) begin
                  if (!found_ff) begin
                     found_in = 1'b1;
                     act_in   = dvru_pkg::ACT_KEPT;
                     idx_in   = k_x[5:0];
                     res_in   = head;
                  end
                  if (cost_ff < head.cost) begin
                     decided_in = 1'b1;
                     idx_in     = k_x[5:0];
                     if (own_ff) begin
                        act_in = dvru_pkg::ACT_REFUSED;
                        res_in = head;
                     end else begin
                        act_in = dvru_pkg::ACT_REPLACED;
                        tail   = fresh;
                        res_in = fresh;
                     end
                  end
               end
               if ((k_x == valid_x) && !found_ff) begin
                  act_in  = dvru_pkg::ACT_APPENDED;
                  idx_in  = k_x[5:0];
                  tail    = fresh;
                  res_in  = fresh;
                  grow_in = 1'b1;
               end
            end
            dvru_pkg::KIND_INSTALL: begin
               if (k_x == valid_x) begin
                  act_in  = dvru_pkg::ACT_INSTALLED;
                  idx_in  = k_x[5:0];
                  tail    = fresh;
                  res_in  = fresh;
                  grow_in = 1'b1;
               end
            end
            default: begin
               if ((k_x == ridx_x) && (ridx_x < valid_x)) begin
                  act_in = dvru_pkg::ACT_READ;
                  res_in = head;
               end
            end
         endcase
      end

      if (load) begin
         valid_in = count_next;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_act_in   = rsp_act_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_count_in = rsp_count_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_act_in   = act_ff;
         rsp_idx_in   = idx_ff;
         rsp_entry_in = res_ff;
         rsp_count_in = count_x[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dvru_pkg::ST_IDLE;
         valid_ff     <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      lim_ff       <= lim_in;
      kind_ff      <= kind_in;
      dest_ff      <= dest_in;
      cost_ff      <= cost_in;
      hop_ff       <= hop_in;
      iface_ff     <= iface_in;
      ridx_ff      <= ridx_in;
      own_ff       <= own_in;
      found_ff     <= found_in;
      decided_ff   <= decided_in;
      grow_ff      <= grow_in;
      act_ff       <= act_in;
      idx_ff       <= idx_in;
      res_ff       <= res_in;
      rsp_act_ff   <= rsp_act_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign chain_ctl.shift = shift;
   assign chain_ctl.tail  = tail;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_act_ff;
   assign rsp_entry_index    = rsp_idx_ff;
   assign rsp_entry_dest     = rsp_entry_ff.dest;
   assign rsp_entry_cost     = rsp_entry_ff.cost;
   assign rsp_entry_next_hop = rsp_entry_ff.next_hop;
   assign rsp_entry_iface    = rsp_entry_ff.iface;
   assign rsp_entry_count    = rsp_count_ff;

endmodule

[hdl/distance_vector_route_update.sv]
// ----------------------------------------------------------------------------
// distance_vector_route_update
// routing table held in a ring of TABLE_DEPTH cells that rotates one slot
// per cycle past a compare and rewrite head while a request word is scanned
// a result word is registered once the ring has made one full turn past the head
// after its request word is taken
// one word at a time, a new word is accepted while the
// previous result still waits to be taken
// reset empties the table and clears the interface registers, no clearing pass
// ----------------------------------------------------------------------------
module distance_vector_route_update #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_dest_addr,
   input  logic [7:0]  req_route_cost,
   input  logic [31:0] req_route_next_hop,
   input  logic [31:0] req_sender_addr,
   input  logic [31:0] req_arrival_iface,
   input  logic        req_first_in_message,
   input  logic [5:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [5:0]  rsp_entry_index,
   output logic [31:0] rsp_entry_dest,
   output logic [7:0]  rsp_entry_cost,
   output logic [31:0] rsp_entry_next_hop,
   output logic [31:0] rsp_entry_iface,
   output logic [6:0]  rsp_entry_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [dvru_pkg::IFACE_SLOTS-1:0][31:0] iface_ff, iface_in;
   logic [2:0]                             count_ff, count_in;
   logic [2:0]                             reg_sel;
   logic                                   wr_en;
   dvru_pkg::own_cfg_type                  own_cfg;
   dvru_pkg::chain_ctl_type                chain_ctl;
   dvru_pkg::entry_type                    chain [TABLE_DEPTH];

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      iface_in = iface_ff;
      count_in = count_ff;
      if (wr_en) begin
         unique case (reg_sel)
            dvru_pkg::REG_IFACE_0:     iface_in[0] = csr_pwdata;
            dvru_pkg::REG_IFACE_1:     iface_in[1] = csr_pwdata;
            dvru_pkg::REG_IFACE_2:     iface_in[2] = csr_pwdata;
            dvru_pkg::REG_IFACE_3:     iface_in[3] = csr_pwdata;
            dvru_pkg::REG_IFACE_COUNT: count_in    = csr_pwdata[2:0];
            default:                   count_in    = count_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         dvru_pkg::REG_IFACE_0:     csr_prdata = iface_ff[0];
         dvru_pkg::REG_IFACE_1:     csr_prdata = iface_ff[1];
         dvru_pkg::REG_IFACE_2:     csr_prdata = iface_ff[2];
         dvru_pkg::REG_IFACE_3:     csr_prdata = iface_ff[3];
         dvru_pkg::REG_IFACE_COUNT: csr_prdata = {29'd0, count_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iface_ff <= '0;
         count_ff <= '0;
      end else begin
         iface_ff <= iface_in;
         count_ff <= count_in;
      end
   end

   assign own_cfg.addr  = iface_ff;
   assign own_cfg.count = count_ff;

   dvru_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .own_cfg              (own_cfg),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_dest_addr        (req_dest_addr),
      .req_route_cost       (req_route_cost),
      .req_route_next_hop   (req_route_next_hop),
      .req_sender_addr      (req_sender_addr),
      .req_arrival_iface    (req_arrival_iface),
      .req_first_in_message (req_first_in_message),
      .req_read_index       (req_read_index),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_action           (rsp_action),
      .rsp_entry_index      (rsp_entry_index),
      .rsp_entry_dest       (rsp_entry_dest),
      .rsp_entry_cost       (rsp_entry_cost),
      .rsp_entry_next_hop   (rsp_entry_next_hop),
      .rsp_entry_iface      (rsp_entry_iface),
      .rsp_entry_count      (rsp_entry_count),
      .head                 (chain[0]),
      .chain_ctl            (chain_ctl)
   );

   // ring of slots, the head cell feeds the tail through the controller
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == TABLE_DEPTH - 1) begin : g_tail
         dvru_cell u_cell (
            .clock     (clock),
            .shift     (chain_ctl.shift),
            .from_next (chain_ctl.tail),
            .entry     (chain[i])
         );
      end else begin : g_body
         dvru_cell u_cell (
            .clock     (clock),
            .shift     (chain_ctl.shift),
            .from_next (chain[i+1]),
            .entry     (chain[i])
         );
      end
   end

endmodule

[sim/distance_vector_route_update_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_update_tb
// drives advertised routes, installs and table reads into the route update
// engine with random gaps and result stalls, mirrors the table and interface
// registers in a scoreboard and checks every result word field by field
// ----------------------------------------------------------------------------
module distance_vector_route_update_tb;

   localparam int TABLE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASES      = 6;
   localparam int PHASE_WORDS = 100;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] dest;
      logic [7:0]  cost;
      logic [31:0] next_hop;
      logic [31:0] sender;
      logic [31:0] arrival;
      logic        first;
      logic [5:0]  read_index;
   } route_word_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [5:0]  index;
      logic [31:0] dest;
      logic [7:0]  cost;
      logic [31:0] next_hop;
      logic [31:0] iface;
      logic [6:0]  count;
   } route_result_type;

   class route_table_scoreboard;
      logic [31:0]      dest_tab[TABLE_DEPTH];
      logic [7:0]       cost_tab[TABLE_DEPTH];
      logic [31:0]      hop_tab[TABLE_DEPTH];
      logic [31:0]      iface_tab[TABLE_DEPTH];
      int               used;
      int               search_limit;
      logic [31:0]      own_iface[dvru_pkg::IFACE_SLOTS];
      logic [2:0]       own_count;
      route_result_type expected_entries[$];
      int               errors;

      function new();
         used = 0;
         search_limit = 0;
         own_count = '0;
         errors = 0;
         for (int i = 0; i < dvru_pkg::IFACE_SLOTS; i++) own_iface[i] = '0;
      endfunction

      function int pending();
         return expected_entries.size();
      endfunction

      function void note_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            dvru_pkg::REG_IFACE_0:     own_iface[0] = value;
            dvru_pkg::REG_IFACE_1:     own_iface[1] = value;
            dvru_pkg::REG_IFACE_2:     own_iface[2] = value;
            dvru_pkg::REG_IFACE_3:     own_iface[3] = value;
            dvru_pkg::REG_IFACE_COUNT: own_count = value[2:0];
            default: ;
         endcase
      endfunction

      function bit owns(logic [31:0] addr);
         int n;
         n = (own_count > dvru_pkg::IFACE_SLOTS) ? dvru_pkg::IFACE_SLOTS : int'(own_count);
         for (int i = 0; i < n; i++)
            if (own_iface[i] == addr) return 1'b1;
         return 1'b0;
      endfunction

      function route_result_type slot_result(logic [2:0] act, int slot);
         route_result_type r;
         r = '0;
         r.action   = act;
         r.index    = slot[5:0];
         r.dest     = dest_tab[slot];
         r.cost     = cost_tab[slot];
         r.next_hop = hop_tab[slot];
         r.iface    = iface_tab[slot];
         return r;
      endfunction

      function route_result_type append(logic [2:0] act, logic [31:0] dest,
                                        logic [7:0] cost, logic [31:0] hop,
                                        logic [31:0] ifc);
         route_result_type r;
         r = '0;
         if (used >= TABLE_DEPTH) begin
            r.action = dvru_pkg::ACT_FULL;
            return r;
         end
         dest_tab[used]  = dest;
         cost_tab[used]  = cost;
         hop_tab[used]   = hop;
         iface_tab[used] = ifc;
         used++;
         return slot_result(act, used - 1);
      endfunction

      function void note_word(route_word_type w);
         route_result_type r;
         logic [7:0]       bumped;
         int               lim;
         int               first_hit;
         bit               found;
         bit               decided;
         r = '0;
         found = 1'b0;
         decided = 1'b0;
         first_hit = 0;
         if (w.kind == dvru_pkg::KIND_ADVERT) begin
            bumped = (w.cost == 8'hFF) ? 8'hFF : w.cost + 8'd1;
            if (w.first) search_limit = used;
            lim = (search_limit < used) ? search_limit : used;
            for (int i = 0; i < lim && !decided; i++) begin
               if (dest_tab[i] == w.dest) begin
                  if (!found) begin
                     found = 1'b1;
                     first_hit = i;
                  end
                  if (bumped < cost_tab[i]) begin
                     decided = 1'b1;
                     if (owns(w.next_hop)) begin
                        r = slot_result(dvru_pkg::ACT_REFUSED, i);
                     end else begin
                        hop_tab[i]   = w.sender;
                        iface_tab[i] = w.arrival;
                        cost_tab[i]  = bumped;
                        r = slot_result(dvru_pkg::ACT_REPLACED, i);
                     end
                  end
               end
            end
            if (!decided) begin
               if (found) r = slot_result(dvru_pkg::ACT_KEPT, first_hit);
               else r = append(dvru_pkg::ACT_APPENDED, w.dest, bumped, w.sender, w.arrival);
            end
         end else if (w.kind == dvru_pkg::KIND_INSTALL) begin
            r = append(dvru_pkg::ACT_INSTALLED, w.dest, w.cost, w.next_hop, w.arrival);
         end else if (w.read_index < used) begin
            r = slot_result(dvru_pkg::ACT_READ, int'(w.read_index));
         end else begin
            r.action = dvru_pkg::ACT_BADIDX;
            r.index  = w.read_index;
         end
         r.count = used[6:0];
         expected_entries.insert(expected_entries.size(), r);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_word(route_result_type got);
         route_result_type want;
         if (expected_entries.size() == 0) begin
            $display("%0t: result word with nothing expected, actual action %0d",
                     $time, got.action);
            errors++;
            return;
         end
         want = expected_entries.pop_front();
         compare("action", 32'(want.action), 32'(got.action));
         compare("entry_index", 32'(want.index), 32'(got.index));
         compare("entry_dest", want.dest, got.dest);
         compare("entry_cost", 32'(want.cost), 32'(got.cost));
         compare("entry_next_hop", want.next_hop, got.next_hop);
         compare("entry_iface", want.iface, got.iface);
         compare("entry_count", 32'(want.count), 32'(got.count));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = '0;
   logic [31:0] req_dest_addr = '0;
   logic [7:0]  req_route_cost = '0;
   logic [31:0] req_route_next_hop = '0;
   logic [31:0] req_sender_addr = '0;
   logic [31:0] req_arrival_iface = '0;
   logic        req_first_in_message = 1'b0;
   logic [5:0]  req_read_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_action;
   logic [5:0]  rsp_entry_index;
   logic [31:0] rsp_entry_dest;
   logic [7:0]  rsp_entry_cost;
   logic [31:0] rsp_entry_next_hop;
   logic [31:0] rsp_entry_iface;
   logic [6:0]  rsp_entry_count;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   route_table_scoreboard sb = new();
   route_result_type      seen;
   logic [31:0]           dest_pool[24];
   bit                    steady = 1'b0;
   int                    stall_left = 0;
   int                    cycles = 0;

   distance_vector_route_update #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_dest_addr(req_dest_addr),
      .req_route_cost(req_route_cost),
      .req_route_next_hop(req_route_next_hop),
      .req_sender_addr(req_sender_addr),
      .req_arrival_iface(req_arrival_iface),
      .req_first_in_message(req_first_in_message),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_action(rsp_action),
      .rsp_entry_index(rsp_entry_index),
      .rsp_entry_dest(rsp_entry_dest),
      .rsp_entry_cost(rsp_entry_cost),
      .rsp_entry_next_hop(rsp_entry_next_hop),
      .rsp_entry_iface(rsp_entry_iface),
      .rsp_entry_count(rsp_entry_count),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver stalls, mostly short with the odd long one
   always @(posedge clock) begin
      if (steady) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 10) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 49) == 0) ? int'($urandom_range(10, 40)) : 0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.action   = rsp_action;
         seen.index    = rsp_entry_index;
         seen.dest     = rsp_entry_dest;
         seen.cost     = rsp_entry_cost;
         seen.next_hop = rsp_entry_next_hop;
         seen.iface    = rsp_entry_iface;
         seen.count    = rsp_entry_count;
         sb.check_word(seen);
      end
   end

   task automatic send_word(route_word_type w);
      int gap;
      gap = (!steady && $urandom_range(0, 99) < 30) ? int'($urandom_range(1, 70)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind             <= w.kind;
      req_dest_addr        <= w.dest;
      req_route_cost       <= w.cost;
      req_route_next_hop   <= w.next_hop;
      req_sender_addr      <= w.sender;
      req_arrival_iface    <= w.arrival;
      req_first_in_message <= w.first;
      req_read_index       <= w.read_index;
      req_valid            <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.note_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic route_word_type make_word(logic [1:0] kind, logic [31:0] dest,
                                                logic [7:0] cost, logic [31:0] hop,
                                                logic [31:0] sender, logic [31:0] arrival,
                                                logic first, logic [5:0] read_index);
      route_word_type w;
      w.kind       = kind;
      w.dest       = dest;
      w.cost       = cost;
      w.next_hop   = hop;
      w.sender     = sender;
      w.arrival    = arrival;
      w.first      = first;
      w.read_index = read_index;
      return w;
   endfunction

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_dest();
      return ($urandom_range(0, 99) < 80) ? dest_pool[$urandom_range(0, 23)] : $urandom;
   endfunction

   function automatic logic [7:0] pick_cost();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd254;
         3:       return 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] pick_hop();
      return ($urandom_range(0, 99) < 30)
             ? sb.own_iface[$urandom_range(0, dvru_pkg::IFACE_SLOTS - 1)]
             : $urandom;
   endfunction

   function automatic logic [5:0] pick_index();
      if (sb.used > 0 && $urandom_range(0, 99) < 70)
         return 6'($urandom_range(0, sb.used - 1));
      return 6'($urandom_range(0, 63));
   endfunction

   function automatic route_word_type side_word();
      int roll;
      logic [1:0] kind;
      roll = $urandom_range(0, 99);
      kind = (roll < 40) ? dvru_pkg::KIND_INSTALL
           : (roll < 85) ? dvru_pkg::KIND_READ : KIND_SPARE;
      return make_word(kind, pick_dest(), pick_cost(), pick_hop(), $urandom,
                       pick_addr(), 1'($urandom_range(0, 1)), pick_index());
   endfunction

   task automatic configure_phase(int phase);
      logic [2:0] counts[PHASES];
      counts = '{3'd4, 3'd0, 3'd7, 3'd1, 3'd3, 3'd5};
      write_reg(dvru_pkg::REG_IFACE_0, pick_addr());
      if ($urandom_range(0, 99) < 60) write_reg(dvru_pkg::REG_IFACE_1, pick_addr());
      if ($urandom_range(0, 99) < 60) write_reg(dvru_pkg::REG_IFACE_2, pick_addr());
      if ($urandom_range(0, 99) < 60) write_reg(dvru_pkg::REG_IFACE_3, pick_addr());
      write_reg(dvru_pkg::REG_IFACE_COUNT, {29'd0, counts[phase]});
   endtask

   task automatic run_phase();
      int             n;
      int             len;
      logic [31:0]    msg_sender;
      logic [31:0]    msg_iface;
      route_word_type w;
      n = 0;
      while (n < PHASE_WORDS) begin
         msg_sender = $urandom;
         msg_iface  = ($urandom_range(0, 1) == 0) ? sb.own_iface[$urandom_range(0, 3)]
                                                  : $urandom;
         len = $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            w = make_word(dvru_pkg::KIND_ADVERT, pick_dest(), pick_cost(), pick_hop(),
                          msg_sender, msg_iface, k == 0, 6'($urandom_range(0, 63)));
            // broken messages and stray senders
            if ($urandom_range(0, 99) < 8) w.first = ~w.first;
            if ($urandom_range(0, 99) < 10) begin
               w.sender  = $urandom;
               w.arrival = $urandom;
            end
            send_word(w);
            n++;
            if ($urandom_range(0, 99) < 25) begin
               send_word(side_word());
               n++;
            end
         end
      end
   endtask

   initial begin
      dest_pool[0] = 32'h0000_0000;
      dest_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 24; i++) dest_pool[i] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(dvru_pkg::REG_IFACE_0, 32'hFFFF_FFFF);
      write_reg(dvru_pkg::REG_IFACE_1, 32'h0000_0000);
      write_reg(dvru_pkg::REG_IFACE_2, 32'hC0A8_0001);
      write_reg(dvru_pkg::REG_IFACE_3, 32'h0A00_0001);
      write_reg(dvru_pkg::REG_IFACE_COUNT, 32'd2);

      // empty table reads, then duplicates, saturation, refusals and installs
      send_word(make_word(dvru_pkg::KIND_READ, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0, 1'b0,
                          6'd0));
      send_word(make_word(KIND_SPARE, '1, '1, '1, '1, '1, 1'b1, 6'd63));
      send_word(make_word(dvru_pkg::KIND_ADVERT, 32'hC0A8_0A05, 8'd0, 32'h1234_5678,
                          32'h0A0A_0A01, 32'h0A00_0001, 1'b1, 6'd0));
      send_word(make_word(dvru_pkg::KIND_ADVERT, 32'hC0A8_0A05, 8'd255, 32'h1234_5678,
                          32'h0A0A_0A01, 32'h0A00_0001, 1'b0, 6'd0));
      send_word(make_word(dvru_pkg::KIND_ADVERT, 32'hC0A8_0A05, 8'd254, 32'h1234_5678,
                          32'h0B0B_0B02, 32'hC0A8_0001, 1'b1, 6'd0));
      send_word(make_word(dvru_pkg::KIND_ADVERT, 32'hC0A8_0A05, 8'd253, 32'hFFFF_FFFF,
                          32'h0B0B_0B02, 32'hC0A8_0001, 1'b0, 6'd0));
      send_word(make_word(dvru_pkg::KIND_ADVERT, 32'hC0A8_0A05, 8'd253, 32'hC0A8_0001,
                          32'h0B0B_0B02, 32'hC0A8_0001, 1'b0, 6'd0));
      send_word(make_word(dvru_pkg::KIND_INSTALL, '1, '1, '1, '1, '1, 1'b0, 6'd0));
      send_word(make_word(dvru_pkg::KIND_INSTALL, '0, '0, '0, '0, '0, 1'b0, 6'd0));
      send_word(make_word(dvru_pkg::KIND_ADVERT, 32'hFFFF_FFFF, 8'd0, 32'h5555_AAAA,
                          32'hAAAA_5555, 32'h0A00_0001, 1'b0, 6'd21));
      send_word(make_word(dvru_pkg::KIND_ADVERT, 32'hFFFF_FFFF, 8'd0, 32'h0000_0000,
                          32'hAAAA_5555, 32'h0A00_0001, 1'b1, 6'd42));
      send_word(make_word(dvru_pkg::KIND_ADVERT, 32'h0000_0000, 8'd255, 32'h5555_AAAA,
                          32'h0101_0101, 32'h0A00_0001, 1'b0, 6'd0));
      wait_idle();
      send_word(make_word(dvru_pkg::KIND_READ, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0, 1'b0,
                          6'd1));
      send_word(make_word(dvru_pkg::KIND_READ, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0, 1'b0,
                          6'd4));
      send_word(make_word(dvru_pkg::KIND_READ, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0, 1'b0,
                          6'd5));
      send_word(make_word(dvru_pkg::KIND_READ, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0, 1'b0,
                          6'd63));
      send_word(make_word(KIND_SPARE, 32'h0, 8'd0, 32'h0, 32'h0, 32'h0, 1'b0, 6'd2));

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         configure_phase(phase);
         steady = (phase == 2);
         run_phase();
      end
      steady = 1'b0;

      wait_idle();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
